// File: rtl/kclm_pkg.sv
// shared types, constants and the lamp command table for the keypad code lock
`default_nettype none

package kclm_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int MASTER_KEYS = 4;
    localparam int BUF_DEPTH   = 8;
    localparam int BUF_IDX_W   = 3;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [3:0]  MAX_TRIES_RESET   = 4'd2;
    localparam logic [31:0] MASTER_CODE_RESET = 32'h3939_3939;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CODE = 1'b1;

    localparam logic [7:0] KEY_NONE = 8'h00;
    localparam logic [7:0] KEY_1    = 8'h31;
    localparam logic [7:0] KEY_2    = 8'h32;
    localparam logic [7:0] KEY_3    = 8'h33;
    localparam logic [7:0] KEY_4    = 8'h34;
    localparam logic [7:0] BYTE_TEMP = 8'h73;

    localparam logic [1:0] ROOM_THREE = 2'd3;

    typedef enum logic [3:0] {
        M_SETUP   = 4'd0,
        M_CHECK   = 4'd1,
        M_WAIT1   = 4'd2,
        M_MASTER  = 4'd3,
        M_NEWCODE = 4'd4,
        M_HALT    = 4'd5,
        M_ROOM    = 4'd6,
        M_LAMP    = 4'd7,
        M_SWITCH  = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_TAKEN     = 4'd1,
        EV_STORED    = 4'd2,
        EV_CORRECT   = 4'd3,
        EV_WRONG     = 4'd4,
        EV_LOCKED    = 4'd5,
        EV_MASTER_OK = 4'd6,
        EV_HALTED    = 4'd7,
        EV_MENU      = 4'd8,
        EV_SENT      = 4'd9,
        EV_WAITING   = 4'd10
    } event_t;

    typedef struct packed {
        event_t          ev;
        logic            send_valid;
        logic [7:0]      send_byte;
        logic [3:0]      tries;
        logic [CNT_W-1:0] digits;
    } res_t;

    // command byte per room, lamp and on/off; zero where the lamp does not exist
    function automatic logic [7:0] lamp_cmd(input logic [1:0] room, input logic [1:0] lamp,
                                            input logic off);
        logic [7:0] on_byte;
        logic [7:0] off_byte;
        on_byte  = 8'h00;
        off_byte = 8'h00;
        unique case ({room, lamp})
            4'b01_01: begin on_byte = "1"; off_byte = "2"; end
            4'b01_10: begin on_byte = "7"; off_byte = "8"; end
            4'b10_01: begin on_byte = "3"; off_byte = "4"; end
            4'b10_10: begin on_byte = "9"; off_byte = "a"; end
            4'b11_01: begin on_byte = "5"; off_byte = "6"; end
            4'b11_10: begin on_byte = "b"; off_byte = "c"; end
            4'b11_11: begin on_byte = "d"; off_byte = "e"; end
            default:  begin on_byte = 8'h00; off_byte = 8'h00; end
        endcase
        return off ? off_byte : on_byte;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kclm_if.sv
// valid/ready channel interfaces for key requests and result requests
`default_nettype none

interface kclm_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

interface kclm_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [3:0] tries_remaining;
    logic [2:0] digits_entered;

    modport source (output valid, output event_res, output send_valid, output send_byte,
                    output tries_remaining, output digits_entered, input ready);
    modport sink (input valid, input event_res, input send_valid, input send_byte,
                  input tries_remaining, input digits_entered, output ready);
endinterface

`default_nettype wire

// File: rtl/kclm_in_stage.sv
// input register for key requests
`default_nettype none

module kclm_in_stage (
    input  wire logic      clk,
    input  wire logic      rst_n,
    kclm_key_if.sink       keys,
    input  wire logic      advance,
    output logic           valid,
    output logic [7:0]     key
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] key_reg;
    logic       take;

    assign keys.ready = !valid_reg || advance;
    assign take       = keys.valid && keys.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg <= keys.key;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;

endmodule

`default_nettype wire

// File: rtl/kclm_core.sv
// lock and menu state, configuration registers and per-key next-state logic
`default_nettype none

module kclm_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [kclm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kclm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            advance,
    input  wire logic [7:0]                      key,
    output kclm_pkg::res_t                       res
);

    kclm_pkg::mode_t mode_reg;
    kclm_pkg::mode_t mode_next;

    logic [3:0]  max_tries_reg;
    logic [31:0] master_code_reg;

    logic [kclm_pkg::CNT_W-1:0] cnt_reg;
    logic [kclm_pkg::CNT_W-1:0] cnt_next;
    logic [3:0]                 tries_reg;
    logic [3:0]                 tries_next;
    logic [1:0]                 room_reg;
    logic [1:0]                 room_next;
    logic [1:0]                 lamp_reg;
    logic [1:0]                 lamp_next;

    logic [7:0] stored_reg [kclm_pkg::BUF_DEPTH];
    logic [7:0] entry_reg  [kclm_pkg::BUF_DEPTH];
    logic [7:0] entry_new  [kclm_pkg::BUF_DEPTH];

    logic [kclm_pkg::CNT_W:0] cnt_inc;
    logic key_nz;
    logic code_done;
    logic master_done;
    logic code_match;
    logic master_match;
    logic store_we;
    logic entry_we;
    logic [7:0] cmd_byte;

    kclm_pkg::event_t ev;
    logic             send_valid;
    logic [7:0]       send_byte;

    assign key_nz      = key != kclm_pkg::KEY_NONE;
    assign cnt_inc     = {1'b0, cnt_reg} + 1'b1;
    assign code_done   = cnt_inc >= (kclm_pkg::CNT_W+1)'(kclm_pkg::CODE_LENGTH);
    assign master_done = cnt_inc >= (kclm_pkg::CNT_W+1)'(kclm_pkg::MASTER_KEYS);
    assign cmd_byte    = kclm_pkg::lamp_cmd(room_reg, lamp_reg, key == kclm_pkg::KEY_2);

    // entry buffer as it stands once this key is written
    always_comb
    begin
        for (int i = 0; i < kclm_pkg::BUF_DEPTH; i++)
        begin
            entry_new[i] = (cnt_reg == kclm_pkg::BUF_IDX_W'(i)) ? key : entry_reg[i];
        end
    end

    always_comb
    begin
        code_match = 1'b1;
        for (int i = 0; i < kclm_pkg::CODE_LENGTH; i++)
        begin
            if (entry_new[i] != stored_reg[i])
            begin
                code_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        master_match = 1'b1;
        for (int i = 0; i < kclm_pkg::MASTER_KEYS; i++)
        begin
            if (entry_new[i] != master_code_reg[8*(kclm_pkg::MASTER_KEYS-1-i) +: 8])
            begin
                master_match = 1'b0;
            end
        end
    end

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (key_nz)
        begin
            unique case (mode_reg)
                kclm_pkg::M_SETUP, kclm_pkg::M_NEWCODE:
                begin
                    if (code_done)
                    begin
                        mode_next = kclm_pkg::M_CHECK;
                    end
                end
                kclm_pkg::M_CHECK:
                begin
                    if (code_done)
                    begin
                        if (code_match)
                        begin
                            mode_next = kclm_pkg::M_ROOM;
                        end
                        else if (tries_reg <= 4'd1)
                        begin
                            mode_next = kclm_pkg::M_WAIT1;
                        end
                    end
                end
                kclm_pkg::M_WAIT1:
                begin
                    if (key == kclm_pkg::KEY_1)
                    begin
                        mode_next = kclm_pkg::M_MASTER;
                    end
                end
                kclm_pkg::M_MASTER:
                begin
                    if (master_done)
                    begin
                        mode_next = master_match ? kclm_pkg::M_NEWCODE : kclm_pkg::M_HALT;
                    end
                end
                kclm_pkg::M_ROOM:
                begin
                    if (key == kclm_pkg::KEY_1 || key == kclm_pkg::KEY_2
                        || key == kclm_pkg::KEY_3)
                    begin
                        mode_next = kclm_pkg::M_LAMP;
                    end
                end
                kclm_pkg::M_LAMP:
                begin
                    if (key == kclm_pkg::KEY_1 || key == kclm_pkg::KEY_2
                        || (key == kclm_pkg::KEY_3 && room_reg == kclm_pkg::ROOM_THREE))
                    begin
                        mode_next = kclm_pkg::M_SWITCH;
                    end
                    else
                    begin
                        mode_next = kclm_pkg::M_ROOM;
                    end
                end
                kclm_pkg::M_SWITCH:
                begin
                    mode_next = kclm_pkg::M_ROOM;
                end
                kclm_pkg::M_HALT:
                begin
                    mode_next = kclm_pkg::M_HALT;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // event, command byte and data state
    always_comb
    begin
        ev         = kclm_pkg::EV_IGNORED;
        send_valid = 1'b0;
        send_byte  = 8'h00;
        cnt_next   = cnt_reg;
        tries_next = tries_reg;
        room_next  = room_reg;
        lamp_next  = lamp_reg;
        store_we   = 1'b0;
        entry_we   = 1'b0;
        if (key_nz)
        begin
            unique case (mode_reg)
                kclm_pkg::M_SETUP, kclm_pkg::M_NEWCODE:
                begin
                    store_we = 1'b1;
                    ev       = kclm_pkg::EV_TAKEN;
                    cnt_next = cnt_inc[kclm_pkg::CNT_W-1:0];
                    if (code_done)
                    begin
                        cnt_next = '0;
                        ev       = kclm_pkg::EV_STORED;
                        if (mode_reg == kclm_pkg::M_NEWCODE)
                        begin
                            tries_next = max_tries_reg;
                        end
                    end
                end
                kclm_pkg::M_CHECK:
                begin
                    entry_we = 1'b1;
                    ev       = kclm_pkg::EV_TAKEN;
                    cnt_next = cnt_inc[kclm_pkg::CNT_W-1:0];
                    if (code_done)
                    begin
                        cnt_next = '0;
                        if (code_match)
                        begin
                            ev = kclm_pkg::EV_CORRECT;
                        end
                        else if (tries_reg > 4'd1)
                        begin
                            tries_next = tries_reg - 4'd1;
                            ev         = kclm_pkg::EV_WRONG;
                        end
                        else
                        begin
                            tries_next = 4'd0;
                            ev         = kclm_pkg::EV_LOCKED;
                        end
                    end
                end
                kclm_pkg::M_WAIT1:
                begin
                    if (key == kclm_pkg::KEY_1)
                    begin
                        cnt_next = '0;
                        ev       = kclm_pkg::EV_TAKEN;
                    end
                    else
                    begin
                        ev = kclm_pkg::EV_WAITING;
                    end
                end
                kclm_pkg::M_MASTER:
                begin
                    entry_we = 1'b1;
                    ev       = kclm_pkg::EV_TAKEN;
                    cnt_next = cnt_inc[kclm_pkg::CNT_W-1:0];
                    if (master_done)
                    begin
                        cnt_next = '0;
                        ev = master_match ? kclm_pkg::EV_MASTER_OK : kclm_pkg::EV_HALTED;
                    end
                end
                kclm_pkg::M_ROOM:
                begin
                    ev = kclm_pkg::EV_MENU;
                    if (key == kclm_pkg::KEY_1 || key == kclm_pkg::KEY_2
                        || key == kclm_pkg::KEY_3)
                    begin
                        room_next = key[1:0];
                    end
                    else if (key == kclm_pkg::KEY_4)
                    begin
                        send_valid = 1'b1;
                        send_byte  = kclm_pkg::BYTE_TEMP;
                        ev         = kclm_pkg::EV_SENT;
                    end
                end
                kclm_pkg::M_LAMP:
                begin
                    ev = kclm_pkg::EV_MENU;
                    if (key == kclm_pkg::KEY_1 || key == kclm_pkg::KEY_2
                        || (key == kclm_pkg::KEY_3 && room_reg == kclm_pkg::ROOM_THREE))
                    begin
                        lamp_next = key[1:0];
                    end
                end
                kclm_pkg::M_SWITCH:
                begin
                    ev = kclm_pkg::EV_MENU;
                    if ((key == kclm_pkg::KEY_1 || key == kclm_pkg::KEY_2)
                        && cmd_byte != 8'h00)
                    begin
                        send_valid = 1'b1;
                        send_byte  = cmd_byte;
                        ev         = kclm_pkg::EV_SENT;
                    end
                end
                kclm_pkg::M_HALT:
                begin
                    ev = kclm_pkg::EV_HALTED;
                end
                default:
                begin
                    ev = kclm_pkg::EV_HALTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= kclm_pkg::M_SETUP;
            cnt_reg         <= '0;
            tries_reg       <= kclm_pkg::MAX_TRIES_RESET;
            room_reg        <= 2'd0;
            lamp_reg        <= 2'd0;
            max_tries_reg   <= kclm_pkg::MAX_TRIES_RESET;
            master_code_reg <= kclm_pkg::MASTER_CODE_RESET;
        end
        else
        begin
            if (advance)
            begin
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                tries_reg <= tries_next;
                room_reg  <= room_next;
                lamp_reg  <= lamp_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kclm_pkg::CFG_MAX_TRIES:   max_tries_reg   <= cfg_data[3:0];
                    kclm_pkg::CFG_MASTER_CODE: master_code_reg <= cfg_data[31:0];
                    default:                   max_tries_reg   <= max_tries_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && store_we)
        begin
            stored_reg[cnt_reg] <= key;
        end
        if (advance && entry_we)
        begin
            entry_reg[cnt_reg] <= key;
        end
    end

    assign res.ev         = ev;
    assign res.send_valid = send_valid;
    assign res.send_byte  = send_byte;
    assign res.tries      = tries_next;
    assign res.digits     = cnt_next;

    // once halted, only reset brings the lock back
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == kclm_pkg::M_HALT |=> mode_reg == kclm_pkg::M_HALT)
        else $error("halted lock left its halt mode");

    // the code counter restarts after a code is stored or a lock decision is taken
    a_cnt_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (ev == kclm_pkg::EV_CORRECT || ev == kclm_pkg::EV_WRONG
                    || ev == kclm_pkg::EV_LOCKED || ev == kclm_pkg::EV_STORED)
        |=> cnt_reg == '0)
        else $error("digit count not cleared after a complete entry");

endmodule

`default_nettype wire

// File: rtl/kclm_out_stage.sv
// result register driving the result channel
`default_nettype none

module kclm_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire kclm_pkg::res_t res,
    output logic                free,
    kclm_res_if.source          results
);

    logic           valid_reg;
    logic           valid_next;
    kclm_pkg::res_t res_reg;

    assign free = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign results.valid           = valid_reg;
    assign results.event_res       = res_reg.ev;
    assign results.send_valid      = res_reg.send_valid;
    assign results.send_byte       = res_reg.send_byte;
    assign results.tries_remaining = res_reg.tries;
    assign results.digits_entered  = res_reg.digits;

endmodule

`default_nettype wire

// File: rtl/keypad_code_lock_menu.sv
// keypad code lock with room, lamp and on/off menu: top level
// a key request is held in the input register, then its result in the result register once that is free
// throughput: one key per cycle while results are taken; the core updates the lock state as a key advances
// a result waiting on the output lets a key enter an empty input register, but then blocks the next key
// reset (rst_n, async, active low): setup entry mode, no digits, two tries, config at defaults
`default_nettype none

module keypad_code_lock_menu (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [kclm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kclm_pkg::CFG_DATA_W-1:0] cfg_data,
    kclm_key_if.sink                             keys,
    kclm_res_if.source                           results
);

    logic           in_valid;
    logic [7:0]     in_key;
    logic           out_free;
    logic           advance;
    kclm_pkg::res_t res;

    assign advance = in_valid && out_free;

    kclm_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (keys),
        .advance (advance),
        .valid   (in_valid),
        .key     (in_key)
    );

    kclm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .key       (in_key),
        .res       (res)
    );

    kclm_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .res     (res),
        .free    (out_free),
        .results (results)
    );

    // a held key request blocks new ones until the result side frees up
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_free |-> !keys.ready)
        else $error("key request accepted while input register is stuck");

    // a command byte travels only with the sent event
    a_send_event: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.send_valid == (results.event_res == kclm_pkg::EV_SENT)))
        else $error("command byte flag and event disagree");

    a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.send_valid |-> results.send_byte == 8'h00)
        else $error("command byte not zero without a send");

endmodule

`default_nettype wire
